// File: rtl/stereo_soft_knee_compressor_assert.svh
// ----------------------------------------------------------------------------
// Stereo soft-knee compressor assertion macros
// Shared property forms for the checker of the compressor ports.
// ----------------------------------------------------------------------------
`ifndef STEREO_SOFT_KNEE_COMPRESSOR_ASSERT_SVH
`define STEREO_SOFT_KNEE_COMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SKC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skc assertion failed");

// Next-cycle implication, disabled while in reset
`define SKC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skc assertion failed");

// Condition that must hold in the cycle after reset is asserted
`define SKC_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("skc assertion failed");

`endif

// File: rtl/skc_pkg.sv
// ----------------------------------------------------------------------------
// Stereo soft-knee compressor package
// Widths, constants, configuration and item types, and the curve tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skc_pkg;

  // Data format
  localparam int SAMPLE_BITS       = 24;
  localparam int DB_FRAC_BITS      = 8;
  localparam int CURVE_TABLE_DEPTH = 256;

  localparam int IDX_BITS      = $clog2(CURVE_TABLE_DEPTH);
  localparam int LOG_FRAC_BITS = 30 - IDX_BITS;
  localparam int EXP_FRAC_BITS = 24 - IDX_BITS;
  localparam int EXPO_BITS     = $clog2(SAMPLE_BITS);
  localparam int DB_SHIFT      = 24 - DB_FRAC_BITS;

  localparam longint unsigned PEAK_FLOOR =
    ((64'd1 << (SAMPLE_BITS - 1)) + 64'd99999) / 64'd100000;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic signed [MUL_W-1:0] DB_PER_OCTAVE = 34'sd101008905;
  localparam logic signed [MUL_W-1:0] OCTAVE_PER_DB = 34'sd44586164;
  localparam logic signed [31:0]      ENV_RESET     = -32'sd1610612736;

  // Table entry widths
  localparam int LOG_W = 25;
  localparam int EXP_W = 26;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ENABLE    = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_INV_RATIO = 3'd2,
    CFG_KNEE      = 3'd3,
    CFG_ATTACK    = 3'd4,
    CFG_RELEASE   = 3'd5,
    CFG_MAKEUP    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] threshold_db;
    logic [16:0] inverse_ratio;
    logic [13:0] knee_width_db;
    logic [23:0] attack_coeff;
    logic [23:0] release_coeff;
    logic [19:0] makeup_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:        1'b1,
    threshold_db:  16'hEC00,
    inverse_ratio: 17'd16384,
    knee_width_db: 14'd0,
    attack_coeff:  24'd16742330,
    release_coeff: 24'd16773721,
    makeup_gain:   20'd65536
  };

  // Frame as classified by the front end
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sl;
    logic [SAMPLE_BITS-1:0] sr;
    logic [SAMPLE_BITS-1:0] peak;
    logic                   bypass;
    logic                   last;
  } item_t;

  typedef logic [LOG_W-1:0] log_tab_t [0:CURVE_TABLE_DEPTH];
  typedef logic [EXP_W-1:0] exp_tab_t [0:CURVE_TABLE_DEPTH];

  // Bitwise log2 of x in [1,2), x in Q1.30, result Q0.24 truncated
  function automatic logic [31:0] log2_frac(input logic [63:0] xin);
    logic [63:0] x;
    logic [31:0] r;
    x = xin;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      t[i] = LOG_W'(log2_frac((64'd1 << 30) + ((64'(i) << 30) / CURVE_TABLE_DEPTH)));
    end
    t[CURVE_TABLE_DEPTH] = LOG_W'(64'd1 << 24);
    return t;
  endfunction

  // Largest Q1.24 value whose log2 does not pass each table point
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] tgt;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      tgt = (64'(i) << 24) / CURVE_TABLE_DEPTH;
      lo  = 64'd1 << 24;
      hi  = (64'd1 << 25) - 64'd1;
      for (int s = 0; s < 26; s++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (64'(log2_frac(mid << 6)) <= tgt) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      t[i] = EXP_W'(lo);
    end
    t[CURVE_TABLE_DEPTH] = EXP_W'(64'd1 << 25);
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// File: rtl/skc_front.sv
// ----------------------------------------------------------------------------
// Compressor front end
// Accepts stereo frames, forms the peak magnitude and tags bypass frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skc_front import skc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample_left,
  input  logic [SAMPLE_BITS-1:0] in_sample_right,
  input  logic                   in_last_frame,
  input  logic                   enable,
  output logic                   push_valid,
  input  logic                   push_ready,
  output item_t                  push_item
);

  logic [SAMPLE_BITS-1:0] abs_l;
  logic [SAMPLE_BITS-1:0] abs_r;
  logic                   seen_r;
  logic                   seen_nxt;

  // Magnitudes; negating full-scale negative gives the right unsigned value
  always_comb begin
    abs_l = in_sample_left[SAMPLE_BITS-1] ? SAMPLE_BITS'(0 - in_sample_left) : in_sample_left;
    abs_r = in_sample_right[SAMPLE_BITS-1] ? SAMPLE_BITS'(0 - in_sample_right)
                                           : in_sample_right;
  end

  // Classify the frame and forward it to the queue
  always_comb begin
    push_item.sl     = in_sample_left;
    push_item.sr     = in_sample_right;
    push_item.peak   = (abs_l > abs_r) ? abs_l : abs_r;
    push_item.bypass = ~enable;
    push_item.last   = in_last_frame;
    push_valid       = in_valid & seen_r;
    in_ready         = push_ready & seen_r;
  end

  // Hold off the first transaction until the cycle after reset
  assign seen_nxt = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/skc_queue.sv
// ----------------------------------------------------------------------------
// Compressor frame queue
// Two-entry queue between the front end and the gain engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skc_queue import skc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  item_t      mem_r [0:1];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the frame payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/skc_back.sv
// ----------------------------------------------------------------------------
// Compressor gain engine
// Sequencer around one shared multiplier: level, envelope, gain curve, gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skc_back import skc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_left,
  output logic [SAMPLE_BITS-1:0] out_right,
  output logic [15:0]            out_reduction_db,
  output logic                   out_last_out
);

  typedef enum logic [22:0] {
    ST_IDLE      = 23'h000001,
    ST_LOG_MUL   = 23'h000002,
    ST_LOG_SUM   = 23'h000004,
    ST_DB_MUL    = 23'h000008,
    ST_ENV_DIFF  = 23'h000010,
    ST_ENV_MUL   = 23'h000020,
    ST_ENV_UPD   = 23'h000040,
    ST_GC_SEL    = 23'h000080,
    ST_SQ_MUL    = 23'h000100,
    ST_DIV_INIT  = 23'h000200,
    ST_DIV       = 23'h000400,
    ST_SLOPE_MUL = 23'h000800,
    ST_RED       = 23'h001000,
    ST_OCT_MUL   = 23'h002000,
    ST_EXP_IDX   = 23'h004000,
    ST_EXP_MUL   = 23'h008000,
    ST_EXP_SUM   = 23'h010000,
    ST_MK_MUL    = 23'h020000,
    ST_TOTAL     = 23'h040000,
    ST_OUT_L     = 23'h080000,
    ST_OUT_R     = 23'h100000,
    ST_OUT_SAT   = 23'h200000,
    ST_PUSH      = 23'h400000
  } state_t;

  localparam logic signed [PROD_W-1:0] SMAX = (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SMIN = -(PROD_W'(1) <<< (SAMPLE_BITS - 1));

  // Round to nearest, ties up, dropping n fraction bits
  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] v,
                                                   input int n);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(1) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] c;
    c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
    return c[SAMPLE_BITS-1:0];
  endfunction

  state_t state_r;
  state_t state_nxt;

  logic signed [SAMPLE_BITS-1:0] sl_r, sl_nxt;
  logic signed [SAMPLE_BITS-1:0] sr_r, sr_nxt;
  logic                          last_r, last_nxt;
  logic [EXPO_BITS-1:0]          e_r, e_nxt;
  logic [IDX_BITS-1:0]           fidx_r, fidx_nxt;
  logic [LOG_FRAC_BITS-1:0]      ffrac_r, ffrac_nxt;
  logic signed [MUL_W-1:0]       acc_r, acc_nxt;
  logic signed [PROD_W-1:0]      prod_r;
  logic [24:0]                   coef_r, coef_nxt;
  logic signed [31:0]            env_r, env_nxt;
  logic signed [15:0]            held_r, held_nxt;
  logic signed [MUL_W-1:0]       red_r, red_nxt;
  logic signed [9:0]             ip_r, ip_nxt;
  logic [23:0]                   efrac_r, efrac_nxt;
  logic [30:0]                   total_r, total_nxt;
  logic [SAMPLE_BITS-1:0]        ol_r, ol_nxt;
  logic [SAMPLE_BITS-1:0]        or_r, or_nxt;
  logic [31:0]                   rem_r, rem_nxt;
  logic [29:0]                   dvd_r, dvd_nxt;
  logic [29:0]                   quo_r, quo_nxt;
  logic [4:0]                    cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]        out_left_r, out_left_nxt;
  logic [SAMPLE_BITS-1:0]        out_right_r, out_right_nxt;
  logic [15:0]                   out_red_r, out_red_nxt;
  logic                          out_last_r, out_last_nxt;

  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;

  // Front-of-chain helpers
  logic [SAMPLE_BITS-1:0]       pk;
  logic [EXPO_BITS-1:0]         lead;
  logic [SAMPLE_BITS+29:0]      norm;
  logic [IDX_BITS:0]            lidx;
  logic [IDX_BITS:0]            lidx1;
  logic [IDX_BITS:0]            eidx1;
  logic [IDX_BITS:0]            eidx0;
  logic [IDX_BITS-1:0]          eidx;

  // Gain computer helpers
  logic signed [MUL_W-1:0]  x_ext;
  logic signed [MUL_W-1:0]  thr;
  logic signed [MUL_W-1:0]  half_w;
  logic signed [MUL_W-1:0]  lower;
  logic signed [MUL_W-1:0]  upper;
  logic signed [MUL_W-1:0]  slope;
  logic [16:0]              inv_c;
  logic signed [MUL_W-1:0]  lv;
  logic signed [PROD_W-1:0] rtmp;
  logic signed [PROD_W-1:0] yq;
  logic [32:0]              rem_sh;
  logic [32:0]              divisor;
  logic                     qbit;
  logic signed [10:0]       sh;

  assign out_valid        = out_valid_r;
  assign out_left         = out_left_r;
  assign out_right        = out_right_r;
  assign out_reduction_db = out_red_r;
  assign out_last_out     = out_last_r;
  assign q_pop            = (state_r == ST_IDLE) & q_valid;

  // Floor the peak and find its leading one
  always_comb begin
    pk   = (64'(q_item.peak) < PEAK_FLOOR) ? SAMPLE_BITS'(PEAK_FLOOR) : q_item.peak;
    lead = '0;
    for (int k = 0; k < SAMPLE_BITS; k++) begin
      if (pk[k]) begin
        lead = EXPO_BITS'(k);
      end
    end
    norm  = {pk, 30'b0} >> lead;
    lidx  = {1'b0, fidx_r};
    lidx1 = {1'b0, fidx_r} + 1'b1;
    eidx  = efrac_r[23:EXP_FRAC_BITS];
    eidx0 = {1'b0, eidx};
    eidx1 = {1'b0, eidx} + 1'b1;
  end

  // Gain curve operands
  always_comb begin
    x_ext   = MUL_W'(env_r);
    thr     = MUL_W'($signed(cfg.threshold_db)) <<< DB_SHIFT;
    half_w  = MUL_W'(cfg.knee_width_db) <<< (DB_SHIFT - 1);
    lower   = thr - half_w;
    upper   = thr + half_w;
    inv_c   = (cfg.inverse_ratio > 17'd65536) ? 17'd65536 : cfg.inverse_ratio;
    slope   = MUL_W'(inv_c) - MUL_W'(65536);
    divisor = 33'(cfg.knee_width_db) << (DB_SHIFT + 1);
    rem_sh  = {rem_r, dvd_r[29]};
    qbit    = (rem_sh >= divisor);
    lv      = MUL_W'(rnd(prod_r, 24));
    rtmp    = rnd(PROD_W'(red_r), DB_SHIFT);
    yq      = rnd(prod_r, 28);
    sh      = 11'sd16 - 11'(ip_r);
  end

  // Select shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LOG_MUL: begin
        mul_a = MUL_W'(LOG_TAB[lidx1] - LOG_TAB[lidx]);
        mul_b = MUL_W'(ffrac_r);
      end
      ST_DB_MUL: begin
        mul_a = acc_r;
        mul_b = DB_PER_OCTAVE;
      end
      ST_ENV_MUL: begin
        mul_a = acc_r;
        mul_b = MUL_W'(coef_r);
      end
      ST_SQ_MUL: begin
        mul_a = acc_r;
        mul_b = acc_r;
      end
      ST_SLOPE_MUL: begin
        mul_a = acc_r;
        mul_b = slope;
      end
      ST_OCT_MUL: begin
        mul_a = red_r;
        mul_b = OCTAVE_PER_DB;
      end
      ST_EXP_MUL: begin
        mul_a = MUL_W'(EXP_TAB[eidx1] - EXP_TAB[eidx0]);
        mul_b = MUL_W'(efrac_r[EXP_FRAC_BITS-1:0]);
      end
      ST_MK_MUL: begin
        mul_a = acc_r;
        mul_b = MUL_W'(cfg.makeup_gain);
      end
      ST_OUT_L: begin
        mul_a = MUL_W'(sl_r);
        mul_b = MUL_W'(total_r);
      end
      ST_OUT_R: begin
        mul_a = MUL_W'(sr_r);
        mul_b = MUL_W'(total_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequence one frame through the gain chain
  always_comb begin
    state_nxt     = state_r;
    sl_nxt        = sl_r;
    sr_nxt        = sr_r;
    last_nxt      = last_r;
    e_nxt         = e_r;
    fidx_nxt      = fidx_r;
    ffrac_nxt     = ffrac_r;
    acc_nxt       = acc_r;
    coef_nxt      = coef_r;
    env_nxt       = env_r;
    held_nxt      = held_r;
    red_nxt       = red_r;
    ip_nxt        = ip_r;
    efrac_nxt     = efrac_r;
    total_nxt     = total_r;
    ol_nxt        = ol_r;
    or_nxt        = or_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_red_nxt   = out_red_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          sl_nxt    = q_item.sl;
          sr_nxt    = q_item.sr;
          last_nxt  = q_item.last;
          e_nxt     = lead;
          fidx_nxt  = norm[29:LOG_FRAC_BITS];
          ffrac_nxt = norm[LOG_FRAC_BITS-1:0];
          if (q_item.bypass) begin
            ol_nxt    = q_item.sl;
            or_nxt    = q_item.sr;
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_LOG_MUL;
          end
        end
      end
      ST_LOG_MUL: state_nxt = ST_LOG_SUM;
      ST_LOG_SUM: begin
        acc_nxt = (MUL_W'(e_r) <<< 24) + MUL_W'(LOG_TAB[lidx])
                + MUL_W'(prod_r >>> LOG_FRAC_BITS) - (MUL_W'(SAMPLE_BITS - 1) <<< 24);
        state_nxt = ST_DB_MUL;
      end
      ST_DB_MUL: state_nxt = ST_ENV_DIFF;
      ST_ENV_DIFF: begin
        acc_nxt   = lv - x_ext;
        coef_nxt  = (lv > x_ext) ? (25'h1000000 - 25'(cfg.attack_coeff))
                                 : (25'h1000000 - 25'(cfg.release_coeff));
        state_nxt = ST_ENV_MUL;
      end
      ST_ENV_MUL: state_nxt = ST_ENV_UPD;
      ST_ENV_UPD: begin
        env_nxt   = 32'(x_ext + MUL_W'(rnd(prod_r, 24)));
        state_nxt = ST_GC_SEL;
      end
      ST_GC_SEL: begin
        if (cfg.knee_width_db != 14'd0) begin
          if (x_ext < lower) begin
            red_nxt   = '0;
            state_nxt = ST_OCT_MUL;
          end else if (x_ext > upper) begin
            acc_nxt   = x_ext - thr;
            state_nxt = ST_SLOPE_MUL;
          end else begin
            acc_nxt   = x_ext - lower;
            state_nxt = ST_SQ_MUL;
          end
        end else if (x_ext > thr) begin
          acc_nxt   = x_ext - thr;
          state_nxt = ST_SLOPE_MUL;
        end else begin
          red_nxt   = '0;
          state_nxt = ST_OCT_MUL;
        end
      end
      ST_SQ_MUL: state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: begin
        rem_nxt   = 32'(prod_r[59:30]);
        dvd_nxt   = prod_r[29:0];
        quo_nxt   = '0;
        cnt_nxt   = 5'd29;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = qbit ? 32'(rem_sh - divisor) : 32'(rem_sh);
        dvd_nxt = {dvd_r[28:0], 1'b0};
        quo_nxt = {quo_r[28:0], qbit};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          acc_nxt   = MUL_W'({quo_r[28:0], qbit});
          state_nxt = ST_SLOPE_MUL;
        end
      end
      ST_SLOPE_MUL: state_nxt = ST_RED;
      ST_RED: begin
        red_nxt   = MUL_W'(rnd(prod_r, 16));
        state_nxt = ST_OCT_MUL;
      end
      ST_OCT_MUL: begin
        if (rtmp < -PROD_W'(32768)) begin
          held_nxt = -16'sd32768;
        end else if (rtmp > PROD_W'(0)) begin
          held_nxt = 16'sd0;
        end else begin
          held_nxt = rtmp[15:0];
        end
        state_nxt = ST_EXP_IDX;
      end
      ST_EXP_IDX: begin
        ip_nxt    = yq[33:24];
        efrac_nxt = yq[23:0];
        state_nxt = ST_EXP_MUL;
      end
      ST_EXP_MUL: state_nxt = ST_EXP_SUM;
      ST_EXP_SUM: begin
        acc_nxt   = MUL_W'(EXP_TAB[eidx0]) + MUL_W'(prod_r >>> EXP_FRAC_BITS);
        state_nxt = ST_MK_MUL;
      end
      ST_MK_MUL: state_nxt = ST_TOTAL;
      ST_TOTAL: begin
        total_nxt = (sh >= 11'sd64) ? 31'd0 : 31'(prod_r >> sh[5:0]);
        state_nxt = ST_OUT_L;
      end
      ST_OUT_L: state_nxt = ST_OUT_R;
      ST_OUT_R: begin
        ol_nxt    = sat(rnd(prod_r, 24));
        state_nxt = ST_OUT_SAT;
      end
      ST_OUT_SAT: begin
        or_nxt    = sat(rnd(prod_r, 24));
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = ol_r;
          out_right_nxt = or_r;
          out_red_nxt   = held_r;
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      env_r       <= ENV_RESET;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_r       <= env_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r      <= mul_a * mul_b;
    sl_r        <= sl_nxt;
    sr_r        <= sr_nxt;
    last_r      <= last_nxt;
    e_r         <= e_nxt;
    fidx_r      <= fidx_nxt;
    ffrac_r     <= ffrac_nxt;
    acc_r       <= acc_nxt;
    coef_r      <= coef_nxt;
    red_r       <= red_nxt;
    ip_r        <= ip_nxt;
    efrac_r     <= efrac_nxt;
    total_r     <= total_nxt;
    ol_r        <= ol_nxt;
    or_r        <= or_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_red_r   <= out_red_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/stereo_soft_knee_compressor.sv
// Sequencing: a compressed frame runs through the log, envelope and gain-curve states, with
//   a 30-step divider inside a soft knee; a disabled frame goes straight to the output state.
// Frames: the engine takes the next frame only once the last one has been pushed out,
//   set by the single shared 34x34 multiplier; a two-entry queue takes frames meanwhile.
// Reset (synchronous, rst_n low): registers to defaults, envelope -96 dB, queue empty;
//   in_ready stays low for the first cycle after reset.
// ----------------------------------------------------------------------------
// Stereo soft-knee compressor
// Configuration registers, front end, frame queue and gain engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_soft_knee_compressor import skc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [23:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample_left,
  input  logic [SAMPLE_BITS-1:0] in_sample_right,
  input  logic                   in_last_frame,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_left,
  output logic [SAMPLE_BITS-1:0] out_right,
  output logic [15:0]            out_reduction_db,
  output logic                   out_last_out
);

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:    cfg_nxt.enable        = cfg_data[0];
        CFG_THRESHOLD: cfg_nxt.threshold_db  = cfg_data[15:0];
        CFG_INV_RATIO: cfg_nxt.inverse_ratio = cfg_data[16:0];
        CFG_KNEE:      cfg_nxt.knee_width_db = cfg_data[13:0];
        CFG_ATTACK:    cfg_nxt.attack_coeff  = cfg_data;
        CFG_RELEASE:   cfg_nxt.release_coeff = cfg_data;
        CFG_MAKEUP:    cfg_nxt.makeup_gain   = cfg_data[19:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  skc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .in_last_frame   (in_last_frame),
    .enable          (cfg_r.enable),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  skc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  skc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (pop_valid),
    .q_item           (pop_item),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left         (out_left),
    .out_right        (out_right),
    .out_reduction_db (out_reduction_db),
    .out_last_out     (out_last_out)
  );

endmodule

`default_nettype wire

// File: rtl/skc_checker.sv
// ----------------------------------------------------------------------------
// Compressor port checker
// Port-level properties of the compressor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_soft_knee_compressor_assert.svh"

module skc_checker import skc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_left,
  input logic [15:0]            out_reduction_db
);

  // Gain reduction is never a boost
  `SKC_ASSERT_IMP(a_red_nonpos, out_valid, out_reduction_db[15] || (out_reduction_db == 16'd0))

  // Reset drops any pending result
  `SKC_ASSERT_RST(a_rst_no_result, !out_valid)

  // Hold off input in the first cycle after a reset edge
  `SKC_ASSERT_RST(a_rst_hold_in, !in_ready)

  // A stalled result holds
  `SKC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left))

endmodule

bind stereo_soft_knee_compressor skc_checker u_skc_checker (.*);

`default_nettype wire
